@@ rtl/dtd_pkg.sv @@
// Shared types, constants and helper functions for the DShot telemetry decoder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package dtd_pkg;

  localparam int GCR_W       = 21;
  localparam int SYM_W       = 5;
  localparam int NIB_W       = 4;
  localparam int NUM_SYMS    = 4;
  localparam int FRAME_W     = NUM_SYMS * NIB_W;
  localparam int MANT_W      = 9;
  localparam int EXPO_W      = 3;
  localparam int PERIOD_W    = 16;
  localparam int ERPM_W      = 26;
  localparam int DIV_STAGES  = ERPM_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int START_BIT   = GCR_W - 1;

  localparam logic [ERPM_W-1:0] ERPM_DIVIDEND = 26'd60000000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_START = 2'd1,
    ST_BAD_GCR  = 2'd2,
    ST_BAD_CRC  = 2'd3
  } status_t;

  // One classified capture, as it leaves the front end.
  typedef struct packed {
    status_t               status;
    logic [FRAME_W-1:0]    frame;
    logic                  edt;
    logic [NIB_W-1:0]      prefix;
    logic [PERIOD_W-1:0]   period;
  } tlm_rec_t;

  typedef struct packed {
    logic             bad;
    logic [NIB_W-1:0] nib;
  } gcr_sym_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] rem;
    logic                qbit;
  } div_step_t;

  // Divider pipeline stage contents.
  typedef struct packed {
    tlm_rec_t            rec;
    logic [PERIOD_W-1:0] rem;
    logic [ERPM_W-1:0]   quot;
  } div_stage_t;

  // 5-bit GCR symbol to nibble; unused codes flag as bad.
  function automatic gcr_sym_t gcr_decode(input logic [SYM_W-1:0] sym);
    gcr_sym_t r;
    r = '{bad: 1'b0, nib: '0};
    unique case (sym)
      5'h19: r.nib = 4'h0;
      5'h1B: r.nib = 4'h1;
      5'h12: r.nib = 4'h2;
      5'h13: r.nib = 4'h3;
      5'h1D: r.nib = 4'h4;
      5'h15: r.nib = 4'h5;
      5'h16: r.nib = 4'h6;
      5'h17: r.nib = 4'h7;
      5'h1A: r.nib = 4'h8;
      5'h09: r.nib = 4'h9;
      5'h0A: r.nib = 4'hA;
      5'h0B: r.nib = 4'hB;
      5'h1E: r.nib = 4'hC;
      5'h0D: r.nib = 4'hD;
      5'h0E: r.nib = 4'hE;
      5'h0F: r.nib = 4'hF;
      default: r.bad = 1'b1;
    endcase
    return r;
  endfunction

  // One restoring-division step: shift in a dividend bit, subtract if it fits.
  function automatic div_step_t div_step(input logic [PERIOD_W-1:0] rem,
                                         input logic                din,
                                         input logic [PERIOD_W-1:0] divisor);
    div_step_t        r;
    logic [PERIOD_W:0] trial;
    trial = {rem, din};
    if (trial >= {1'b0, divisor}) begin
      r.qbit = 1'b1;
      r.rem  = PERIOD_W'(trial - {1'b0, divisor});
    end else begin
      r.qbit = 1'b0;
      r.rem  = trial[PERIOD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dtd_if.sv @@
// Valid/ready channel interfaces for the DShot telemetry decoder: capture in,
// decoded result out, and the configuration write channel. Uses dtd_pkg.
`default_nettype none

interface dtd_in_if;
  logic                        valid;
  logic                        ready;
  logic [dtd_pkg::GCR_W-1:0]   gcr_word;

  modport source (output valid, output gcr_word, input ready);
  modport sink   (input valid, input gcr_word, output ready);
endinterface

interface dtd_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [dtd_pkg::FRAME_W-1:0]    decoded_frame;
  logic                           is_edt;
  logic [dtd_pkg::NIB_W-1:0]      frame_prefix;
  logic [dtd_pkg::PERIOD_W-1:0]   motor_period;
  logic [dtd_pkg::ERPM_W-1:0]     erpm;

  modport source (output valid, output status, output decoded_frame, output is_edt,
                  output frame_prefix, output motor_period, output erpm, input ready);
  modport sink   (input valid, input status, input decoded_frame, input is_edt,
                  input frame_prefix, input motor_period, input erpm, output ready);
endinterface

interface dtd_cfg_if;
  logic valid;
  logic ready;
  logic edt_enabled;

  modport source (output valid, output edt_enabled, input ready);
  modport sink   (input valid, input edt_enabled, output ready);
endinterface

`default_nettype wire

@@ rtl/dtd_front.sv @@
// Front end: GCR symbol decode, start-bit and CRC checks, EDT flag and period
// expansion. Purely combinational into the queue. Uses dtd_pkg, dtd_in_if.
`default_nettype none

module dtd_front (
  dtd_in_if.sink              tlm_in,
  input  wire logic           edt_enabled,
  output dtd_pkg::tlm_rec_t   push_rec,
  output logic                push_valid,
  input  wire logic           push_ready
);

  dtd_pkg::gcr_sym_t              syms [dtd_pkg::NUM_SYMS];
  logic                           any_bad;
  logic [dtd_pkg::FRAME_W-1:0]    raw_frame;
  logic [dtd_pkg::NIB_W-1:0]      crc_want;
  logic [dtd_pkg::MANT_W-1:0]     mant;
  logic [dtd_pkg::EXPO_W-1:0]     expo;
  logic                           ok;

  always_comb begin
    any_bad = 1'b0;
    for (int k = 0; k < dtd_pkg::NUM_SYMS; k++) begin
      syms[k] = dtd_pkg::gcr_decode(tlm_in.gcr_word[k*dtd_pkg::SYM_W +: dtd_pkg::SYM_W]);
      raw_frame[k*dtd_pkg::NIB_W +: dtd_pkg::NIB_W] = syms[k].nib;
      any_bad = any_bad | syms[k].bad;
    end
  end

  assign crc_want = ~(raw_frame[15:12] ^ raw_frame[11:8] ^ raw_frame[7:4]);
  assign expo     = raw_frame[15:13];
  assign mant     = raw_frame[12:4];

  always_comb begin
    push_rec = '0;
    priority if (!tlm_in.gcr_word[dtd_pkg::START_BIT]) begin
      push_rec.status = dtd_pkg::ST_NO_START;
    end else if (any_bad) begin
      push_rec.status = dtd_pkg::ST_BAD_GCR;
    end else if (crc_want != raw_frame[3:0]) begin
      push_rec.status = dtd_pkg::ST_BAD_CRC;
      push_rec.frame  = raw_frame;
    end else begin
      push_rec.status = dtd_pkg::ST_OK;
      push_rec.frame  = raw_frame;
    end
    push_rec.prefix = push_rec.frame[15:12];
    ok = (push_rec.status == dtd_pkg::ST_OK);
    if (ok) begin
      // 9-bit mantissa shifted by at most 7 fits the 16-bit period exactly
      push_rec.period = dtd_pkg::PERIOD_W'({{(dtd_pkg::PERIOD_W-dtd_pkg::MANT_W){1'b0}}, mant}
                        << expo);
      push_rec.edt    = edt_enabled && (push_rec.prefix != '0) && !push_rec.prefix[0];
    end
  end

  assign push_valid   = tlm_in.valid;
  assign tlm_in.ready = push_ready;

endmodule

`default_nettype wire

@@ rtl/dtd_queue.sv @@
// Short flop-based queue between front end and divider so each side can
// stall on its own. Uses dtd_pkg.
`default_nettype none

module dtd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  input  wire dtd_pkg::tlm_rec_t   push_rec,
  output logic                     push_ready,
  output logic                     pop_valid,
  output dtd_pkg::tlm_rec_t        pop_rec,
  input  wire logic                pop_ready
);

  dtd_pkg::tlm_rec_t             mem [dtd_pkg::QUEUE_DEPTH];
  logic [dtd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dtd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dtd_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != dtd_pkg::QCNT_W'(dtd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [dtd_pkg::QPTR_W-1:0] ptr_inc(input logic [dtd_pkg::QPTR_W-1:0] p);
    return (p == dtd_pkg::QPTR_W'(dtd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + dtd_pkg::QCNT_W'(push) - dtd_pkg::QCNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dtd_pkg::QCNT_W'(dtd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + dtd_pkg::QCNT_W'($past(push))
                              - dtd_pkg::QCNT_W'($past(pop)))
    else $error("queue count out of step with requests");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

@@ rtl/dtd_divider.sv @@
// Back end: pipelined restoring divider for eRPM = 60000000 / period, one
// quotient bit per stage, last stage doubles as output register. Uses dtd_pkg.
`default_nettype none

module dtd_divider (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire dtd_pkg::tlm_rec_t   in_rec,
  output logic                     in_ready,
  dtd_out_if.source                tlm_out
);

  localparam int N = dtd_pkg::DIV_STAGES;

  dtd_pkg::div_stage_t   stage [N];
  logic [N-1:0]          valid;
  logic                  adv;
  dtd_pkg::div_stage_t   head;

  // Whole pipe moves unless the finished request is held at the output.
  assign adv      = !valid[N-1] || tlm_out.ready;
  assign in_ready = adv;

  always_comb begin
    head      = '0;
    head.rec  = in_rec;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    dtd_pkg::div_stage_t src;
    dtd_pkg::div_step_t  st;

    if (k == 0) begin : g_first
      assign src = head;
    end else begin : g_rest
      assign src = stage[k-1];
    end

    assign st = dtd_pkg::div_step(src.rem, dtd_pkg::ERPM_DIVIDEND[N-1-k], src.rec.period);

    always_ff @(posedge clk) begin
      if (adv) begin
        stage[k].rec  <= src.rec;
        stage[k].rem  <= st.rem;
        stage[k].quot <= {src.quot[dtd_pkg::ERPM_W-2:0], st.qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[N-2:0], in_valid};
    end
  end

  assign tlm_out.valid         = valid[N-1];
  assign tlm_out.status        = stage[N-1].rec.status;
  assign tlm_out.decoded_frame = stage[N-1].rec.frame;
  assign tlm_out.is_edt        = stage[N-1].rec.edt;
  assign tlm_out.frame_prefix  = stage[N-1].rec.prefix;
  assign tlm_out.motor_period  = stage[N-1].rec.period;
  // zero divisor gives all ones from the restoring steps
  assign tlm_out.erpm = (stage[N-1].rec.period == '0) ? '0 : stage[N-1].quot;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid[N-1] && (stage[N-1].rec.period != '0) |-> stage[N-1].rem < stage[N-1].rec.period)
    else $error("divider remainder not below divisor");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    valid[N-1] && (stage[N-1].rec.status != dtd_pkg::ST_OK)
      |-> (stage[N-1].rec.period == '0) && !stage[N-1].rec.edt)
    else $error("failed frame carries period or EDT flag");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(valid))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

@@ rtl/dshot_telemetry_decoder.sv @@
// Bidirectional DShot telemetry decoder top level: configuration register,
// front end, queue and divider. Uses dtd_pkg, dtd_if, dtd_front, dtd_queue, dtd_divider.
`default_nettype none

// Takes one 21-bit GCR capture per request on tlm_in and returns one result per
// capture on tlm_out, in order. A new capture can be taken every cycle while
// tlm_out.ready stays high, so the sustained rate is then one result per clock.
// An accepted capture passes one register in the input queue and then the 26
// stages of the eRPM divider, which produces one quotient bit per stage.
// The output holds while tlm_out.ready is low; a two-entry queue keeps tlm_in
// accepting until that backpressure has filled it. The edt_enabled register is
// written through cfg (always ready) and resets to 0; write it only when idle.
module dshot_telemetry_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  dtd_in_if.sink      tlm_in,
  dtd_out_if.source   tlm_out,
  dtd_cfg_if.sink     cfg
);

  logic                edt_enabled;
  dtd_pkg::tlm_rec_t   push_rec;
  logic                push_valid;
  logic                push_ready;
  dtd_pkg::tlm_rec_t   pop_rec;
  logic                pop_valid;
  logic                pop_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edt_enabled <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      edt_enabled <= cfg.edt_enabled;
    end
  end

  dtd_front u_front (
    .tlm_in      (tlm_in),
    .edt_enabled (edt_enabled),
    .push_rec    (push_rec),
    .push_valid  (push_valid),
    .push_ready  (push_ready)
  );

  dtd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_rec    (pop_rec),
    .pop_ready  (pop_ready)
  );

  dtd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop_valid),
    .in_rec   (pop_rec),
    .in_ready (pop_ready),
    .tlm_out  (tlm_out)
  );

endmodule

`default_nettype wire

@@ test/tb_dshot_telemetry_decoder.sv @@
// Self-checking testbench for dshot_telemetry_decoder: directed and random GCR
// captures, random input gaps and output backpressure, results checked in order.
// Depends on rtl/dtd_pkg.sv, rtl/dtd_if.sv and the decoder RTL.

module tb_dshot_telemetry_decoder;

  localparam int PHASE_ITEMS = 400;
  localparam int DRAIN_CYCLES = 32;

  // GCR code for each nibble value; all other 5-bit codes are illegal.
  localparam logic [4:0] NIB_TO_SYM [16] = '{
    5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
    5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F
  };
  localparam logic [4:0] BAD_SYMS [16] = '{
    5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06, 5'h07,
    5'h08, 5'h0C, 5'h10, 5'h11, 5'h14, 5'h18, 5'h1C, 5'h1F
  };

  typedef struct packed {
    dtd_pkg::status_t status;
    logic [15:0]      frame;
    logic             edt;
    logic [3:0]       prefix;
    logic [15:0]      period;
    logic [25:0]      erpm;
  } tlm_result_t;

  class tlm_scoreboard;
    bit          edt_enabled;
    tlm_result_t awaited[$];
    int unsigned errors;

    function tlm_result_t decode_capture(logic [20:0] w);
      tlm_result_t r;
      logic [4:0]  sym;
      logic [11:0] payload;
      logic [3:0]  crc;
      bit          hit;
      r = '0;
      r.status = dtd_pkg::ST_OK;
      if (!w[20]) begin
        r.status = dtd_pkg::ST_NO_START;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (r.status == dtd_pkg::ST_OK) begin
            sym = w[5*k +: 5];
            hit = 0;
            for (int n = 0; n < 16; n++) begin
              if (NIB_TO_SYM[n] == sym) begin
                r.frame[4*k +: 4] = 4'(n);
                hit = 1;
              end
            end
            if (!hit) r.status = dtd_pkg::ST_BAD_GCR;
          end
        end
        if (r.status == dtd_pkg::ST_BAD_GCR) r.frame = '0;
      end
      if (r.status == dtd_pkg::ST_OK) begin
        payload = r.frame[15:4];
        crc = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
        if (crc != r.frame[3:0]) r.status = dtd_pkg::ST_BAD_CRC;
      end
      r.prefix = r.frame[15:12];
      if (r.status == dtd_pkg::ST_OK) begin
        // exponent in frame[15:13], mantissa in frame[12:4]
        r.period = 16'({7'b0, r.frame[12:4]} << r.frame[15:13]);
        r.erpm = (r.period != 0) ? 26'(32'd60000000 / {16'b0, r.period}) : '0;
        r.edt = edt_enabled && r.prefix != 0 && !r.prefix[0];
      end
      return r;
    endfunction

    function void note_capture(logic [20:0] w);
      awaited.push_back(decode_capture(w));
    endfunction

    function void report_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(tlm_result_t got);
      tlm_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t unrequested result: expected none, got %0h", $time, got);
        return;
      end
      want = awaited.pop_front();
      report_field("status", want.status, got.status);
      report_field("decoded_frame", want.frame, got.frame);
      report_field("is_edt", want.edt, got.edt);
      report_field("frame_prefix", want.prefix, got.prefix);
      report_field("motor_period", want.period, got.period);
      report_field("erpm", want.erpm, got.erpm);
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  tlm_scoreboard sb = new();

  dtd_in_if  tlm_in();
  dtd_out_if tlm_out();
  dtd_cfg_if cfg();

  dshot_telemetry_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .tlm_in (tlm_in),
    .tlm_out(tlm_out),
    .cfg    (cfg)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [15:0] seal_payload(logic [11:0] p);
    return {p, ~(p[3:0] ^ p[7:4] ^ p[11:8])};
  endfunction

  function automatic logic [20:0] encode_frame(logic [15:0] f);
    return {1'b1, NIB_TO_SYM[f[15:12]], NIB_TO_SYM[f[11:8]],
            NIB_TO_SYM[f[7:4]], NIB_TO_SYM[f[3:0]]};
  endfunction

  function automatic logic [20:0] random_capture();
    int unsigned pick;
    int unsigned k;
    logic [15:0] f;
    logic [20:0] w;
    pick = $urandom_range(0, 99);
    f = seal_payload(12'($urandom));
    w = encode_frame(f);
    if (pick >= 95) begin
      w = 21'($urandom);
    end else if (pick >= 90) begin
      w[20] = 1'b0;
    end else if (pick >= 80) begin
      k = $urandom_range(0, 3);
      w[5*k +: 5] = BAD_SYMS[$urandom_range(0, 15)];
    end else if (pick >= 70) begin
      w = encode_frame(f ^ {12'h000, 4'($urandom_range(1, 15))});
    end
    return w;
  endfunction

  task automatic send_capture(logic [20:0] w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      tlm_in.valid <= 1'b0;
      @(posedge clk);
    end
    tlm_in.valid    <= 1'b1;
    tlm_in.gcr_word <= w;
    do @(posedge clk); while (!tlm_in.ready);
    sb.note_capture(w);
  endtask

  task automatic write_edt(bit v);
    cfg.valid       <= 1'b1;
    cfg.edt_enabled <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.edt_enabled = v;
  endtask

  task automatic wait_idle();
    tlm_in.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [20:0] w;
    // register still at its reset value here
    send_capture(encode_frame(seal_payload(12'h000)));      // zero period
    send_capture(encode_frame(seal_payload(12'h001)));      // shortest period
    send_capture(encode_frame(seal_payload(12'hFFF)));      // longest period
    send_capture(encode_frame(seal_payload(12'h1FF)));
    send_capture(encode_frame(seal_payload(12'h8C5)));
    send_capture(encode_frame(seal_payload(12'h6E7)));
    send_capture(encode_frame(seal_payload(12'h9D4)));
    send_capture(encode_frame(seal_payload(12'h123) ^ 16'h0001));
    send_capture(encode_frame(seal_payload(12'hFFF) ^ 16'h000F));
    send_capture(21'h000000);
    send_capture(21'h0FFFFF);
    send_capture(21'h100000);
    send_capture(21'h1FFFFF);
    for (int k = 0; k < 4; k++) begin
      w = encode_frame(seal_payload(12'h5A3));
      w[5*k +: 5] = 5'h1C;
      send_capture(w);
    end
    wait_idle();
    write_edt(1'b1);
    send_capture(encode_frame(seal_payload(12'h200)));      // EDT frame
    send_capture(encode_frame(seal_payload(12'hE00)));      // EDT, zero period
    send_capture(encode_frame(seal_payload(12'h3AB)));      // odd prefix
    send_capture(encode_frame(seal_payload(12'h0B7)));      // zero prefix
    send_capture(encode_frame(seal_payload(12'h4F0) ^ 16'h0008));
    send_capture(encode_frame(seal_payload(12'h600)) & ~21'h100000);
    wait_idle();
  endtask

  task automatic run_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_capture(random_capture());
    wait_idle();
  endtask

  // result side: random stalls, every accepted result checked in order
  initial begin
    forever begin
      tlm_out.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      @(posedge clk);
      if (!rst && tlm_out.valid && tlm_out.ready)
        sb.check_result('{status: dtd_pkg::status_t'(tlm_out.status),
                          frame:  tlm_out.decoded_frame,
                          edt:    tlm_out.is_edt,
                          prefix: tlm_out.frame_prefix,
                          period: tlm_out.motor_period,
                          erpm:   tlm_out.erpm});
    end
  end

  initial begin
    in_idle_pct  = 38;
    out_idle_pct = 77;
    rst             <= 1'b1;
    tlm_in.valid    <= 1'b0;
    tlm_in.gcr_word <= '0;
    cfg.valid       <= 1'b0;
    cfg.edt_enabled <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    write_edt(1'b0);
    run_random(PHASE_ITEMS);

    in_idle_pct  = 77;
    out_idle_pct = 38;
    write_edt(1'b1);
    run_random(PHASE_ITEMS);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_edt(1'($urandom));
    run_random(PHASE_ITEMS);

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
